FILE: rtl/lzwc_pkg.sv
// Shared constants, payload types and state encoding for the LZW encoder.
`timescale 1ns / 1ps
package lzwc_pkg;

  localparam int unsigned CODE_W     = 12;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned KEY_W      = CODE_W + BYTE_W;
  localparam int unsigned NF_W       = CODE_W + 1;
  localparam int unsigned DICT_SIZE  = 4096;
  localparam int unsigned SEG_LEN    = 16;
  localparam int unsigned NUM_SEG    = DICT_SIZE / SEG_LEN;
  localparam int unsigned NUM_GRP    = NUM_SEG / SEG_LEN;

  localparam logic [CODE_W-1:0] END_CODE   = CODE_W'(256);
  localparam logic [NF_W-1:0]   FIRST_CODE = NF_W'(257);
  localparam logic [NF_W-1:0]   CODE_LIMIT = NF_W'(DICT_SIZE);

  // Edges from key load until the reduced hit code is registered.
  localparam logic [2:0] SRCH_CYCLES = 3'd4;

  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] codeword;
    logic              last;
  } out_t;

  typedef struct packed {
    logic            wr;
    logic [NF_W-1:0] next_free;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_EMIT_A,
    S_EMIT_B
  } state_e;

endpackage

FILE: rtl/lzwc_cell.sv
// One dictionary cell: holds an entry, compares it to the key, extends the hit chain.
`timescale 1ns / 1ps
module lzwc_cell import lzwc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [CODE_W-1:0] idx_i,
  input  logic [CODE_W-1:0] chain_i,
  output logic [CODE_W-1:0] chain_o
);

  logic [KEY_W-1:0] entry_q;
  logic             hit_q;
  logic             live;

  // Only codes already handed out since the last finish can match.
  assign live = ({1'b0, idx_i} >= FIRST_CODE) && ({1'b0, idx_i} < ctl_i.next_free);

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr && ({1'b0, idx_i} == ctl_i.next_free)) begin
      entry_q <= ctl_i.key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= live && (entry_q == ctl_i.key);
    end
  end

  assign chain_o = chain_i | (hit_q ? idx_i : '0);

endmodule

FILE: rtl/lzwc_or16.sv
// Registered OR of sixteen hit codes (at most one is nonzero).
`timescale 1ns / 1ps
module lzwc_or16 import lzwc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CODE_W-1:0] codes_i [SEG_LEN],
  output logic [CODE_W-1:0] code_o
);

  logic [CODE_W-1:0] code_d;
  logic [CODE_W-1:0] code_q;

  always_comb begin
    code_d = '0;
    for (int k = 0; k < SEG_LEN; k++) begin
      code_d = code_d | codes_i[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
    end else begin
      code_q <= code_d;
    end
  end

  assign code_o = code_q;

endmodule

FILE: rtl/lzw_compressor_12bit.sv
// Top level of the fixed-width LZW encoder: control, cell row and hit reduction.
`timescale 1ns / 1ps
//  channel | direction | payload | handshake
//  in      | input     | in_t    | in_valid_i / in_stall_o
//  out     | output    | out_t   | out_valid_o / out_stall_i
//
//  A byte that starts a match is taken while idle; a byte that needs a lookup
//  stalls the input through key load, cell compare, segment chain, two 16-way
//  OR stages, then the decision. Each emitted code adds an emit state.
//  Reset is asynchronous; the cell entries need no clearing, codes at or above
//  the next free code never match. Out stalls hold the result and the encoder in its emit states.
module lzw_compressor_12bit import lzwc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  state_e state_q, state_d;
  logic [CODE_W-1:0] match_q, match_d;
  logic              mvalid_q, mvalid_d;
  logic [NF_W-1:0]   nfree_q, nfree_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [2:0]        cnt_q, cnt_d;
  out_t              res_a_q, res_a_d;
  logic              has_b_q, has_b_d;
  out_t              out_q, out_d;
  logic              ovalid_q, ovalid_d;
  logic              wr;

  logic [CODE_W-1:0] chain [DICT_SIZE];
  logic [CODE_W-1:0] seg_q [NUM_SEG];
  logic [CODE_W-1:0] grp   [NUM_GRP];
  logic [CODE_W-1:0] found;
  cell_ctl_t         ctl;

  logic in_acc;
  logic out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !ovalid_q || !out_stall_i;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  assign ctl.wr        = wr;
  assign ctl.next_free = nfree_q;
  assign ctl.key       = key_q;

  for (genvar i = 0; i < DICT_SIZE; i++) begin : g_cell
    logic [CODE_W-1:0] cin;
    if (i % SEG_LEN == 0) begin : g_head
      assign cin = '0;
    end else begin : g_body
      assign cin = chain[i-1];
    end
    lzwc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .idx_i   (CODE_W'(i)),
      .chain_i (cin),
      .chain_o (chain[i])
    );
  end

  for (genvar s = 0; s < NUM_SEG; s++) begin : g_seg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        seg_q[s] <= '0;
      end else begin
        seg_q[s] <= chain[s*SEG_LEN + SEG_LEN - 1];
      end
    end
  end

  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    lzwc_or16 u_or (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .codes_i (seg_q[g*SEG_LEN +: SEG_LEN]),
      .code_o  (grp[g])
    );
  end

  lzwc_or16 u_or_final (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .codes_i (grp),
    .code_o  (found)
  );

  always_comb begin
    state_d  = state_q;
    match_d  = match_q;
    mvalid_d = mvalid_q;
    nfree_d  = nfree_q;
    key_d    = key_q;
    cnt_d    = cnt_q;
    res_a_d  = res_a_q;
    has_b_d  = has_b_q;
    out_d    = out_q;
    ovalid_d = ovalid_q && out_stall_i;
    wr       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.command == CMD_FINISH) begin
            if (mvalid_q) begin
              res_a_d = '{codeword: match_q, last: 1'b0};
              has_b_d = 1'b1;
            end else begin
              res_a_d = '{codeword: END_CODE, last: 1'b1};
              has_b_d = 1'b0;
            end
            mvalid_d = 1'b0;
            match_d  = '0;
            nfree_d  = FIRST_CODE;
            state_d  = S_EMIT_A;
          end else if (!mvalid_q) begin
            match_d  = CODE_W'(in_data_i.data_byte);
            mvalid_d = 1'b1;
          end else begin
            key_d   = {match_q, in_data_i.data_byte};
            cnt_d   = '0;
            state_d = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == SRCH_CYCLES) begin
          if (found != '0) begin
            match_d = found;
            state_d = S_IDLE;
          end else begin
            res_a_d = '{codeword: match_q, last: 1'b0};
            has_b_d = 1'b0;
            if (nfree_q < CODE_LIMIT) begin
              wr      = 1'b1;
              nfree_d = nfree_q + NF_W'(1);
            end
            match_d = CODE_W'(key_q[BYTE_W-1:0]);
            state_d = S_EMIT_A;
          end
        end
      end
      S_EMIT_A: begin
        if (out_free) begin
          out_d    = res_a_q;
          ovalid_d = 1'b1;
          state_d  = has_b_q ? S_EMIT_B : S_IDLE;
        end
      end
      S_EMIT_B: begin
        if (out_free) begin
          out_d    = '{codeword: END_CODE, last: 1'b1};
          ovalid_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      match_q  <= '0;
      mvalid_q <= 1'b0;
      nfree_q  <= FIRST_CODE;
      cnt_q    <= '0;
      has_b_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      match_q  <= match_d;
      mvalid_q <= mvalid_d;
      nfree_q  <= nfree_d;
      cnt_q    <= cnt_d;
      has_b_q  <= has_b_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    res_a_q <= res_a_d;
    out_q   <= out_d;
  end

  a_nfree_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nfree_q >= FIRST_CODE) && (nfree_q <= CODE_LIMIT))
    else $error("next free code out of range");

  a_srch_has_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> mvalid_q)
    else $error("lookup without a pending match");

  a_hit_assigned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH && cnt_q == SRCH_CYCLES && found != '0) |->
      ({1'b0, found} >= FIRST_CODE) && ({1'b0, found} < nfree_q))
    else $error("hit on an unassigned code");

  a_finish_restores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.command == CMD_FINISH) |=>
      (!mvalid_q && nfree_q == FIRST_CODE && state_q == S_EMIT_A))
    else $error("finish did not restore the dictionary");

endmodule

FILE: tb/lzw_code_checker.sv
// Checker for the LZW encoder: predicts emitted codes and compares them with the block.
`timescale 1ns / 1ps
module lzw_code_checker import lzwc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned codes_pending_o
);

  logic [CODE_W-1:0] cur_code;
  logic              cur_live;
  logic [NF_W-1:0]   free_code;
  logic [KEY_W-1:0]  dict_key [DICT_SIZE];
  out_t              code_queue [$];

  assign codes_pending_o = code_queue.size();

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  task automatic push_code(input logic [CODE_W-1:0] code, input logic last);
    out_t item;
    item.codeword = code;
    item.last = last;
    code_queue.push_back(item);
  endtask

  // Advance the encoder image by one accepted transaction.
  task automatic encode_item(input in_t item);
    logic [KEY_W-1:0] key;
    int               hit;
    hit = -1;
    if (item.command == CMD_FINISH) begin
      if (cur_live) push_code(cur_code, 1'b0);
      push_code(END_CODE, 1'b1);
      cur_code = '0;
      cur_live = 1'b0;
      free_code = FIRST_CODE;
    end else if (!cur_live) begin
      cur_code = CODE_W'(item.data_byte);
      cur_live = 1'b1;
    end else begin
      key = {cur_code, item.data_byte};
      for (int c = FIRST_CODE; c < free_code; c++) begin
        if (dict_key[c] == key) begin
          hit = c;
          break;
        end
      end
      if (hit >= 0) begin
        cur_code = CODE_W'(hit);
      end else begin
        push_code(cur_code, 1'b0);
        if (free_code < CODE_LIMIT) begin
          dict_key[free_code[CODE_W-1:0]] = key;
          free_code++;
        end
        cur_code = CODE_W'(item.data_byte);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      cur_code = '0;
      cur_live = 1'b0;
      free_code = FIRST_CODE;
      code_queue.delete();
      fail_count_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) encode_item(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (code_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected code %0d", out_data_i.codeword));
        end else begin
          want = code_queue.pop_front();
          if (out_data_i.codeword !== want.codeword)
            report_mismatch($sformatf("codeword %0d, expected %0d",
                                      out_data_i.codeword, want.codeword));
          if (out_data_i.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b",
                                      out_data_i.last, want.last));
        end
      end
    end
  end

endmodule

FILE: tb/tb_lzw_compressor_12bit.sv
// Testbench top for the LZW encoder: clock, reset, byte stream stimulus and verdict.
`timescale 1ns / 1ps
module tb_lzw_compressor_12bit;
  import lzwc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  int unsigned fail_count;
  int unsigned codes_pending;
  int unsigned cycle_count;
  bit          calm;
  int unsigned sent;

  lzw_compressor_12bit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  lzw_code_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .codes_pending_o(codes_pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 14);
  end

  // Present one transaction, with an optional random gap before it.
  task automatic send_item(input logic cmd, input logic [7:0] byte_val);
    if (!calm) begin
      while ($urandom_range(99) < 14) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_data <= {cmd, byte_val};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  // Bytes from a small alphabet repeat often and grow long matches.
  function automatic logic [7:0] pick_byte(input int unsigned span);
    return (span >= 255) ? 8'($urandom) : 8'($urandom_range(span));
  endfunction

  initial begin
    int unsigned span;
    int unsigned len;
    cycle_count = 0;
    sent = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty stream, extremes, repeats, single byte stream.
    send_item(CMD_FINISH, 8'h00);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, 8'hAA);
    send_item(CMD_DATA, 8'h55);
    send_item(CMD_FINISH, 8'hFF);
    send_item(CMD_DATA, 8'h41);
    send_item(CMD_FINISH, 8'h41);
    repeat (8) send_item(CMD_DATA, 8'h61);
    send_item(CMD_FINISH, 8'h00);

    // Hold off until every emitted code has come out.
    in_valid <= 1'b0;
    @(negedge clk);
    while (codes_pending != 0) @(negedge clk);

    // Random streams; one longer stream closes the run.
    while (sent < 460) begin
      calm = (sent >= 250 && sent < 350);
      span = ($urandom_range(3) == 0) ? 255 : $urandom_range(1, 7);
      len = $urandom_range(1, 40);
      repeat (len) send_item(CMD_DATA, pick_byte(span));
      send_item(CMD_FINISH, 8'($urandom));
    end
    calm = 1'b1;
    repeat (100) send_item(CMD_DATA, 8'($urandom));
    repeat (40) send_item(CMD_DATA, pick_byte(3));
    send_item(CMD_FINISH, 8'h00);
    calm = 1'b0;

    in_valid <= 1'b0;
    @(negedge clk);
    while (codes_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
